FILE: src/xpf_pkg.sv
package xpf_pkg;

    localparam int MAX_PACKET = 2048;
    localparam int ADDR_W     = $clog2(MAX_PACKET);
    localparam int CNT_W      = 12;
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;

    typedef enum logic [2:0] {
        ACT_DATA   = 3'd0,
        ACT_LOST   = 3'd1,
        ACT_PARITY = 3'd2,
        ACT_FINISH = 3'd3,
        ACT_FETCH  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_SHORT    = 3'd1,
        STAT_LOSS     = 3'd2,
        STAT_LENGTH   = 3'd3,
        STAT_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic {
        KIND_REPORT = 1'b0,
        KIND_BYTE   = 1'b1
    } kind_t;

    typedef struct packed {
        action_t             action;
        logic [BYTE_W-1:0]   data_byte;
        logic                packet_end;
    } item_t;

    typedef struct packed {
        kind_t               kind;
        status_t             status;
        logic [CNT_W-1:0]    out_length;
        logic [BYTE_W-1:0]   out_byte;
        logic                out_last;
    } result_t;

endpackage

FILE: src/xpf_ram.sv
module xpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/xor_parity_packet_fec.sv
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    item (xpf_pkg::item_t)
// result    out        result_valid, one cycle result (xpf_pkg::result_t)
// config    in         cfg_we                  cfg_wdata (mode)
//
// One word is taken every cycle; busy never rises. A word reads the XOR store in
// the command stage and writes it back in the store stage; its result passes
// s1_res_reg, then res_reg. A forwarding register covers a read of the entry
// the preceding word wrote. Reset needs no clearing pass, since the high-water
// mark hides stale entries. The receiver cannot stall the result strobe.
module xor_parity_packet_fec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  xpf_pkg::item_t    item,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    output logic              result_valid,
    output xpf_pkg::result_t  result
);

    localparam int AW = xpf_pkg::ADDR_W;
    localparam int CW = xpf_pkg::CNT_W;
    localparam int LW = xpf_pkg::LEN_W;
    localparam int BW = xpf_pkg::BYTE_W;

    logic          mode_reg;
    logic [CW-1:0] hw_reg, hw_next;
    logic [CW-1:0] bi_reg, bi_next;
    logic [LW-1:0] lx_reg, lx_next;
    logic [1:0]    lc_reg, lc_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic [CW-1:0] rl_reg, rl_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic          ovf_reg, ovf_next;
    logic          done_reg, done_next;

    logic             s1_valid_reg, s1_valid_next;
    xpf_pkg::result_t s1_res_reg, s1_res_next;
    logic             s1_from_ram_reg, s1_from_ram_next;
    logic             s1_wr_reg, s1_wr_next;
    logic             s1_use_old_reg, s1_use_old_next;
    logic [AW-1:0]    s1_addr_reg, s1_addr_next;
    logic [BW-1:0]    s1_data_reg, s1_data_next;

    logic          fw_valid_reg;
    logic [AW-1:0] fw_addr_reg;
    logic [BW-1:0] fw_data_reg;

    logic             res_valid_reg;
    xpf_pkg::result_t res_reg, res_next;

    logic [AW-1:0] rd_addr;
    logic [BW-1:0] ram_q;
    logic [BW-1:0] rd_data;
    logic [BW-1:0] wr_data;
    logic          take;

    xpf_ram #(
        .WIDTH (BW),
        .DEPTH (xpf_pkg::MAX_PACKET)
    ) u_store (
        .clk   (clk),
        .we    (s1_wr_reg),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign busy = 1'b0;
    assign take = start && !busy;

    // Command stage: scalar bookkeeping and the store read address.
    always_comb
    begin
        logic [CW:0] hw_plus1;
        logic [CW:0] hw_plus2;
        logic [CW-1:0] bi_inc;

        hw_next          = hw_reg;
        bi_next          = bi_reg;
        lx_next          = lx_reg;
        lc_next          = lc_reg;
        pc_next          = pc_reg;
        rl_next          = rl_reg;
        rp_next          = rp_reg;
        ovf_next         = ovf_reg;
        done_next        = done_reg;
        s1_valid_next    = 1'b0;
        s1_res_next      = '0;
        s1_from_ram_next = 1'b0;
        s1_wr_next       = 1'b0;
        s1_use_old_next  = 1'b0;
        s1_addr_next     = '0;
        s1_data_next     = item.data_byte;
        rd_addr          = '0;
        bi_inc           = '0;

        if (take && done_reg && (item.action == xpf_pkg::ACT_DATA
                || item.action == xpf_pkg::ACT_LOST
                || item.action == xpf_pkg::ACT_PARITY))
        begin
            hw_next   = '0;
            bi_next   = '0;
            lx_next   = '0;
            lc_next   = '0;
            pc_next   = '0;
            ovf_next  = 1'b0;
            rl_next   = '0;
            rp_next   = '0;
            done_next = 1'b0;
        end

        hw_plus1 = {1'b0, hw_next} + (CW+1)'(1);
        hw_plus2 = {1'b0, hw_next} + (CW+1)'(2);

        if (take)
        begin
            case (item.action)
                xpf_pkg::ACT_DATA:
                begin
                    if (bi_next < CW'(xpf_pkg::MAX_PACKET))
                    begin
                        rd_addr         = bi_next[AW-1:0];
                        s1_addr_next    = bi_next[AW-1:0];
                        s1_wr_next      = 1'b1;
                        s1_use_old_next = (bi_next < hw_next);
                        bi_inc          = bi_next + CW'(1);
                        bi_next         = bi_inc;
                        if (bi_inc > hw_next)
                        begin
                            hw_next = bi_inc;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.packet_end && bi_next != '0)
                    begin
                        lx_next = lx_next ^ {{(LW-CW){1'b0}}, bi_next};
                        bi_next = '0;
                    end
                end
                xpf_pkg::ACT_LOST:
                begin
                    if (bi_next != '0)
                    begin
                        lx_next = lx_next ^ {{(LW-CW){1'b0}}, bi_next};
                        bi_next = '0;
                    end
                    if (lc_next != 2'd3)
                    begin
                        lc_next = lc_next + 2'd1;
                    end
                end
                xpf_pkg::ACT_PARITY:
                begin
                    if (mode_reg)
                    begin
                        if (pc_next < hw_next)
                        begin
                            rd_addr         = pc_next[AW-1:0];
                            s1_addr_next    = pc_next[AW-1:0];
                            s1_wr_next      = 1'b1;
                            s1_use_old_next = 1'b1;
                        end
                        else if (pc_next == hw_next)
                        begin
                            lx_next = lx_next ^ {{(LW-BW){1'b0}}, item.data_byte};
                        end
                        else if ({1'b0, pc_next} == hw_plus1)
                        begin
                            lx_next = lx_next ^ {item.data_byte, {(LW-BW){1'b0}}};
                        end
                        if (pc_next != {CW{1'b1}})
                        begin
                            pc_next = pc_next + CW'(1);
                        end
                    end
                end
                xpf_pkg::ACT_FINISH:
                begin
                    if (bi_next != '0)
                    begin
                        lx_next = lx_next ^ {{(LW-CW){1'b0}}, bi_next};
                        bi_next = '0;
                    end
                    s1_valid_next    = 1'b1;
                    s1_res_next.kind = xpf_pkg::KIND_REPORT;
                    rl_next          = '0;
                    if (ovf_next)
                    begin
                        s1_res_next.status = xpf_pkg::STAT_OVERFLOW;
                    end
                    else if (!mode_reg)
                    begin
                        rl_next = hw_plus2[CW-1:0];
                    end
                    else if ({1'b0, pc_next} < hw_plus2)
                    begin
                        s1_res_next.status = xpf_pkg::STAT_SHORT;
                    end
                    else if (lc_next != 2'd1)
                    begin
                        s1_res_next.status = xpf_pkg::STAT_LOSS;
                    end
                    else if (lx_next > {{(LW-CW){1'b0}}, hw_next})
                    begin
                        s1_res_next.status = xpf_pkg::STAT_LENGTH;
                    end
                    else
                    begin
                        rl_next = lx_next[CW-1:0];
                    end
                    s1_res_next.out_length = rl_next;
                    rp_next   = '0;
                    done_next = 1'b1;
                end
                xpf_pkg::ACT_FETCH:
                begin
                    s1_valid_next          = 1'b1;
                    s1_res_next.kind       = xpf_pkg::KIND_BYTE;
                    s1_res_next.out_last   = 1'b1;
                    if (rp_next < rl_next)
                    begin
                        if (rp_next < hw_next)
                        begin
                            rd_addr          = rp_next[AW-1:0];
                            s1_addr_next     = rp_next[AW-1:0];
                            s1_from_ram_next = 1'b1;
                        end
                        else if (rp_next == hw_next)
                        begin
                            s1_res_next.out_byte = lx_next[BW-1:0];
                        end
                        else if ({1'b0, rp_next} == hw_plus1)
                        begin
                            s1_res_next.out_byte = lx_next[LW-1:LW-BW];
                        end
                        rp_next = rp_next + CW'(1);
                        s1_res_next.out_last = (rp_next == rl_next);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Store stage: forwarded read data, write-back and result.
    always_comb
    begin
        if (fw_valid_reg && fw_addr_reg == s1_addr_reg)
        begin
            rd_data = fw_data_reg;
        end
        else
        begin
            rd_data = ram_q;
        end
        wr_data  = (s1_use_old_reg ? rd_data : '0) ^ s1_data_reg;
        res_next = s1_res_reg;
        if (s1_from_ram_reg)
        begin
            res_next.out_byte = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            hw_reg          <= '0;
            bi_reg          <= '0;
            lx_reg          <= '0;
            lc_reg          <= '0;
            pc_reg          <= '0;
            rl_reg          <= '0;
            rp_reg          <= '0;
            ovf_reg         <= 1'b0;
            done_reg        <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_wr_reg       <= 1'b0;
            s1_from_ram_reg <= 1'b0;
            fw_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            hw_reg          <= hw_next;
            bi_reg          <= bi_next;
            lx_reg          <= lx_next;
            lc_reg          <= lc_next;
            pc_reg          <= pc_next;
            rl_reg          <= rl_next;
            rp_reg          <= rp_next;
            ovf_reg         <= ovf_next;
            done_reg        <= done_next;
            s1_valid_reg    <= s1_valid_next;
            s1_wr_reg       <= s1_wr_next;
            s1_from_ram_reg <= s1_from_ram_next;
            fw_valid_reg    <= s1_wr_reg;
            res_valid_reg   <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_res_reg     <= s1_res_next;
        s1_use_old_reg <= s1_use_old_next;
        s1_addr_reg    <= s1_addr_next;
        s1_data_reg    <= s1_data_next;
        fw_addr_reg    <= s1_addr_reg;
        fw_data_reg    <= wr_data;
        res_reg        <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

FILE: test/xpf_checker.sv
module xpf_checker
    import xpf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    input  logic    result_valid,
    input  result_t result,
    output int      mismatches,
    output int      pending,
    output int      results_checked,
    output int      recoveries
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN_MISMATCHES = 40;

    logic [BYTE_W-1:0] xor_mem [MAX_PACKET];
    logic [CNT_W-1:0]  high_water;
    logic [CNT_W-1:0]  byte_index;
    logic [CNT_W-1:0]  parity_count;
    logic [CNT_W-1:0]  packet_length;
    logic [CNT_W-1:0]  read_ptr;
    logic [LEN_W-1:0]  length_xor;
    logic [1:0]        lost_count;
    logic              overflow;
    logic              group_done;
    logic              fec_mode;
    result_t           expected_q [$];

    task automatic report_mismatch(string what, int want_v, int got_v);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
        begin
            $display("%0t ns: mismatch in %s: expected %0d, got %0d",
                     $time, what, want_v, got_v);
        end
    endtask

    function automatic void clear_group_state();
        high_water   = '0;
        byte_index   = '0;
        length_xor   = '0;
        lost_count   = '0;
        parity_count = '0;
        overflow     = 1'b0;
    endfunction

    // The first data, loss or parity word after a finish starts a fresh group.
    function automatic void open_group();
        if (group_done)
        begin
            clear_group_state();
            packet_length = '0;
            read_ptr      = '0;
            group_done    = 1'b0;
        end
    endfunction

    function automatic void close_open_packet();
        if (byte_index != '0)
        begin
            length_xor = length_xor ^ LEN_W'(byte_index);
            byte_index = '0;
        end
    endfunction

    function automatic void apply_command(item_t w);
        result_t           r;
        logic [BYTE_W-1:0] old;
        r = '0;
        case (w.action)
            ACT_DATA:
            begin
                open_group();
                if (byte_index < MAX_PACKET)
                begin
                    old = (byte_index < high_water) ? xor_mem[byte_index] : '0;
                    xor_mem[byte_index] = old ^ w.data_byte;
                    byte_index++;
                    if (byte_index > high_water)
                        high_water = byte_index;
                end
                else
                begin
                    overflow = 1'b1;
                end
                if (w.packet_end)
                    close_open_packet();
            end
            ACT_LOST:
            begin
                open_group();
                close_open_packet();
                if (lost_count != 2'd3)
                    lost_count++;
            end
            ACT_PARITY:
            begin
                open_group();
                if (fec_mode)
                begin
                    if (parity_count < high_water && parity_count < MAX_PACKET)
                        xor_mem[parity_count] = xor_mem[parity_count] ^ w.data_byte;
                    else if (parity_count == high_water)
                        length_xor[7:0] = length_xor[7:0] ^ w.data_byte;
                    else if (parity_count == high_water + CNT_W'(1))
                        length_xor[15:8] = length_xor[15:8] ^ w.data_byte;
                    if (parity_count != '1)
                        parity_count++;
                end
            end
            ACT_FINISH:
            begin
                close_open_packet();
                r.kind   = KIND_REPORT;
                r.status = STAT_OK;
                if (overflow)
                    r.status = STAT_OVERFLOW;
                else if (!fec_mode)
                    r.out_length = high_water + CNT_W'(2);
                else if (parity_count < high_water + CNT_W'(2))
                    r.status = STAT_SHORT;
                else if (lost_count != 2'd1)
                    r.status = STAT_LOSS;
                else if (length_xor > LEN_W'(high_water))
                    r.status = STAT_LENGTH;
                else
                begin
                    r.out_length = length_xor[CNT_W-1:0];
                    recoveries++;
                end
                packet_length = r.out_length;
                read_ptr      = '0;
                group_done    = 1'b1;
                expected_q.push_back(r);
            end
            ACT_FETCH:
            begin
                r.kind     = KIND_BYTE;
                r.status   = STAT_OK;
                r.out_last = 1'b1;
                if (read_ptr < packet_length)
                begin
                    if (read_ptr < high_water)
                        r.out_byte = xor_mem[read_ptr];
                    else if (read_ptr == high_water)
                        r.out_byte = length_xor[7:0];
                    else if (read_ptr == high_water + CNT_W'(1))
                        r.out_byte = length_xor[15:8];
                    read_ptr++;
                    r.out_last = (read_ptr == packet_length);
                end
                expected_q.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (xor_mem[i])
                xor_mem[i] = '0;
            clear_group_state();
            packet_length   = '0;
            read_ptr        = '0;
            group_done      = 1'b0;
            fec_mode        = 1'b0;
            expected_q.delete();
            mismatches      = 0;
            pending         = 0;
            results_checked = 0;
            recoveries      = 0;
        end
        else
        begin
            if (result_valid)
            begin
                results_checked++;
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected, kind", -1,
                                    int'(result.kind));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.kind !== want.kind)
                        report_mismatch("kind", int'(want.kind), int'(result.kind));
                    if (result.status !== want.status)
                        report_mismatch("status", int'(want.status), int'(result.status));
                    if (result.out_length !== want.out_length)
                        report_mismatch("out_length", int'(want.out_length),
                                        int'(result.out_length));
                    if (result.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(want.out_byte),
                                        int'(result.out_byte));
                    if (result.out_last !== want.out_last)
                        report_mismatch("out_last", int'(want.out_last),
                                        int'(result.out_last));
                end
            end
            if (start && !busy)
                apply_command(item);
            if (cfg_we)
                fec_mode = cfg_wdata;
            pending = expected_q.size();
        end
    end

endmodule

FILE: test/tb_xor_parity_packet_fec.sv
module tb_xor_parity_packet_fec;
    timeunit 1ns;
    timeprecision 1ps;

    import xpf_pkg::*;

    localparam int TOTAL_WORDS        = 1500;
    localparam int DRAIN_CYCLES       = 4;
    localparam int SETTLE_CYCLES      = 10;
    localparam int STALL_LIMIT        = 4000;
    localparam int FIRST_SPARE_ACTION = int'(ACT_FETCH) + 1;
    localparam int LAST_SPARE_ACTION  = (1 << $bits(action_t)) - 1;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    start     = 1'b0;
    logic    busy;
    item_t   item      = '0;
    logic    cfg_we    = 1'b0;
    logic    cfg_wdata = 1'b0;
    logic    result_valid;
    result_t result;

    int mismatches;
    int pending;
    int results_checked;
    int recoveries;
    int words_sent  = 0;
    int idle_free   = 0;
    int quiet_count = 0;
    int groups_run  = 0;
    logic cur_mode  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xor_parity_packet_fec dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    xpf_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .result_valid    (result_valid),
        .result          (result),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .recoveries      (recoveries)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            quiet_count <= 0;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
            if (quiet_count == STALL_LIMIT)
            begin
                $display("tb_xor_parity_packet_fec: FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (idle_free > 0)
        begin
            idle_free--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5)
        begin
            idle_free = $urandom_range(20, 200);
            return 0;
        end
        if (r < 500)
            return 0;
        if (r < 850)
            return $urandom_range(1, 3);
        if (r < 980)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 90)
            return $urandom_range(1, 16);
        if (r < 98)
            return $urandom_range(17, 64);
        return $urandom_range(65, 300);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(action_t act, logic [7:0] value, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= '{action: act, data_byte: value, packet_end: last};
        do
            @(posedge clk);
        while (busy);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_data(logic [7:0] value, logic last);
        send_word(ACT_DATA, value, last);
    endtask

    task automatic send_marker(action_t act);
        send_word(act, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_fetches(int count);
        repeat (count) send_marker(ACT_FETCH);
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(logic m);
        pause_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = m;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_marker(action_t'($urandom_range(FIRST_SPARE_ACTION, LAST_SPARE_ACTION)));
            1: send_marker(ACT_FETCH);
            default: send_word(ACT_PARITY, 8'($urandom), 1'($urandom));
        endcase
    endtask

    // Most groups are well formed; a few leave packets open, add noise,
    // change the parity length or get the loss count wrong.
    task automatic run_group();
        logic [7:0]  parity_bytes [$];
        logic [15:0] len_sum;
        logic [7:0]  b;
        logic        keep_open;
        int          n_pkts;
        int          longest;
        int          lost_at;
        int          plen;
        int          flavor;
        int          n_fetch;
        n_pkts  = cur_mode ? $urandom_range(2, 4) : $urandom_range(1, 4);
        longest = pick_length();
        flavor  = $urandom_range(0, 9);
        lost_at = -1;
        if (cur_mode)
            lost_at = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, n_pkts - 1);
        if (cur_mode && flavor == 9 && $urandom_range(0, 1) == 0)
            lost_at = -1;
        len_sum = '0;
        for (int k = 0; k < longest; k++)
            parity_bytes.push_back(8'h00);
        for (int p = 0; p < n_pkts; p++)
        begin
            plen      = (p == 0) ? longest : $urandom_range(0, longest);
            len_sum   = len_sum ^ 16'(plen);
            keep_open = (flavor == 7) && ($urandom_range(0, 2) == 0);
            if (p == lost_at)
            begin
                for (int k = 0; k < plen; k++)
                    parity_bytes[k] = parity_bytes[k] ^ 8'($urandom);
                send_marker(ACT_LOST);
            end
            else if (plen == 0)
            begin
                if (!cur_mode)
                    send_marker(ACT_LOST);
            end
            else
            begin
                for (int k = 0; k < plen; k++)
                begin
                    b = 8'($urandom);
                    parity_bytes[k] = parity_bytes[k] ^ b;
                    send_data(b, (k == plen - 1) && !keep_open);
                end
            end
            if (flavor == 8 && $urandom_range(0, 3) == 0)
                send_noise();
        end
        if (cur_mode)
        begin
            if (flavor == 9 && lost_at >= 0)
                send_marker(ACT_LOST);
            parity_bytes.push_back(len_sum[7:0]);
            parity_bytes.push_back(len_sum[15:8]);
            if (flavor == 8)
            begin
                if ($urandom_range(0, 1) == 0)
                    repeat ($urandom_range(1, 3)) void'(parity_bytes.pop_back());
                else
                    repeat ($urandom_range(1, 3)) parity_bytes.push_back(8'($urandom));
            end
            foreach (parity_bytes[k])
                send_word(ACT_PARITY, parity_bytes[k], 1'($urandom));
        end
        else if (flavor == 8)
        begin
            send_word(ACT_PARITY, 8'($urandom), 1'($urandom));
        end
        send_marker(ACT_FINISH);
        n_fetch = ($urandom_range(0, 4) == 0) ? $urandom_range(0, longest)
                                              : longest + 2 + $urandom_range(0, 2);
        send_fetches(n_fetch);
        if ($urandom_range(0, 7) == 0)
        begin
            send_marker(ACT_FINISH);
            send_fetches($urandom_range(1, 3));
        end
        groups_run++;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_mode(1'b0);

        // Encode mode: empty output, spare actions, ignored parity, empty group.
        send_marker(ACT_FETCH);
        for (int a = FIRST_SPARE_ACTION; a <= LAST_SPARE_ACTION; a++)
            send_marker(action_t'(a));
        send_word(ACT_PARITY, 8'hAA, 1'b0);
        send_marker(ACT_FINISH);
        send_fetches(3);

        // Two packets and an empty one; the last packet is left open.
        send_data(8'hFF, 1'b0);
        send_data(8'h00, 1'b1);
        send_marker(ACT_LOST);
        send_data(8'h5A, 1'b0);
        send_marker(ACT_FINISH);
        send_fetches(4);
        send_marker(ACT_FINISH);
        send_fetches(1);

        set_mode(1'b1);

        // Loss count saturates; parity is missing as well.
        send_data(8'h12, 1'b0);
        repeat (4) send_marker(ACT_LOST);
        send_marker(ACT_FINISH);

        // No loss at all.
        send_data(8'h7E, 1'b1);
        repeat (3) send_word(ACT_PARITY, 8'($urandom), 1'b0);
        send_marker(ACT_FINISH);

        // Clean recovery of a one-byte packet.
        send_data(8'h11, 1'b0);
        send_data(8'h22, 1'b1);
        send_marker(ACT_LOST);
        send_word(ACT_PARITY, 8'h22, 1'b0);
        send_word(ACT_PARITY, 8'h22, 1'b0);
        send_word(ACT_PARITY, 8'h03, 1'b0);
        send_word(ACT_PARITY, 8'h00, 1'b0);
        send_marker(ACT_FINISH);
        send_fetches(2);

        // Recovered length beyond the longest packet.
        send_data(8'h01, 1'b1);
        send_marker(ACT_LOST);
        send_word(ACT_PARITY, 8'h5C, 1'b0);
        send_word(ACT_PARITY, 8'hFF, 1'b0);
        send_word(ACT_PARITY, 8'h0F, 1'b0);
        send_marker(ACT_FINISH);

        while (words_sent < TOTAL_WORDS)
        begin
            if ($urandom_range(0, 3) == 0)
                set_mode(1'($urandom));
            else if ($urandom_range(0, 7) == 0)
                pause_until_drained();
            run_group();
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Ran %0d random groups in both modes; %0d results checked.",
                 groups_run, results_checked);
        $display("Decode finishes reporting a recovered packet: %0d.", recoveries);
        if (mismatches == 0 && pending == 0)
            $display("tb_xor_parity_packet_fec: PASS");
        else
            $display("tb_xor_parity_packet_fec: FAIL");
        $finish;
    end

endmodule

FILE: xor_parity_packet_fec.f
src/xpf_pkg.sv
src/xpf_ram.sv
src/xor_parity_packet_fec.sv
test/xpf_checker.sv
test/tb_xor_parity_packet_fec.sv
